### hdl/drlfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the delta run-length frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package drlfe_pkg;

    // operation codes
    localparam logic [1:0] OP_RECORD    = 2'd0;
    localparam logic [1:0] OP_END_FLUSH = 2'd1;

    // configuration register byte addresses
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [15:0] CAPACITY_RESET = 16'd4096;
    localparam logic [17:0] CAPACITY_MARGIN = 18'd17;

    localparam int QUEUE_DEPTH = 2;

    // byte slots of one record, in stream order
    localparam int NUM_SLOTS = 11;
    localparam logic [3:0] SLOT_HDR     = 4'd0;
    localparam logic [3:0] SLOT_FLAGS   = 4'd1;
    localparam logic [3:0] SLOT_BUTTONS = 4'd2;
    localparam logic [3:0] SLOT_STEER   = 4'd3;
    localparam logic [3:0] SLOT_PEDALS  = 4'd4;
    localparam logic [3:0] SLOT_FINE_LO = 4'd5;
    localparam logic [3:0] SLOT_FINE_HI = 4'd6;
    localparam logic [3:0] SLOT_RUN3    = 4'd7;
    localparam logic [3:0] SLOT_RUN2    = 4'd8;
    localparam logic [3:0] SLOT_RUN1    = 4'd9;
    localparam logic [3:0] SLOT_RUN0    = 4'd10;

    localparam logic [30:0] RUN_MAX = 31'h7FFF_FFFF;

    // one record to be serialized
    typedef struct packed {
        logic [7:0]           header;
        logic [7:0]           flags;
        logic [7:0]           buttons;
        logic [7:0]           steer;
        logic [7:0]           pedals;
        logic [15:0]          fine;
        logic [30:0]          run;
        logic [15:0]          pos;
        logic                 full;
        logic [31:0]          frames;
        logic [NUM_SLOTS-1:0] mask;
    } t_rec;

endpackage

### hdl/drlfe_front.sv
`timescale 1ns / 1ps
// Front end: compares each frame with the last one, tracks the repeat run,
// write position and stop state, and builds record descriptors. Uses drlfe_pkg.
module drlfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_frame_flags,
    input  logic [7:0]        i_frame_buttons,
    input  logic [7:0]        i_frame_steer,
    input  logic [7:0]        i_throttle_level,
    input  logic [3:0]        i_brake_level,
    input  logic [15:0]       i_wheel_fine,
    input  logic [15:0]       i_capacity,
    output logic              o_enq,
    output drlfe_pkg::t_rec   o_rec
);

    logic [3:0]  r_last_hdr;
    logic [7:0]  r_last_flags;
    logic [7:0]  r_last_buttons;
    logic [7:0]  r_last_steer;
    logic [7:0]  r_last_pedals;
    logic [15:0] r_last_fine;
    logic [30:0] r_run;
    logic        r_pending;
    logic [15:0] r_wr_pos;
    logic        r_stopped;
    logic [31:0] r_total;

    logic [7:0]  pedals;
    logic        fine_chg;
    logic [3:0]  chg;
    logic        is_rec;
    logic        rec_flush;
    logic        end_flush;
    logic        long_run;
    logic        has_fine;
    logic [3:0]  n_len;
    logic [16:0] n_pos;
    logic        cap_hit;

    always_comb begin
        pedals   = i_throttle_level | {i_brake_level, 4'b0000};
        fine_chg = i_frame_flags[7] && (!r_last_flags[7] || (i_wheel_fine != r_last_fine));
        chg      = {(pedals != r_last_pedals) || fine_chg,
                    i_frame_steer != r_last_steer,
                    i_frame_buttons != r_last_buttons,
                    i_frame_flags != r_last_flags};
        is_rec    = (i_operation == drlfe_pkg::OP_RECORD);
        rec_flush = is_rec && !r_stopped && r_pending && (chg != 4'd0);
        end_flush = (i_operation == drlfe_pkg::OP_END_FLUSH) && !r_stopped && r_pending;
        long_run  = (r_run[30:3] != 28'd0);
        has_fine  = r_last_hdr[3] && r_last_flags[7];

        o_rec.header  = {long_run, r_last_hdr, r_run[2:0]};
        o_rec.flags   = r_last_flags;
        o_rec.buttons = r_last_buttons;
        o_rec.steer   = r_last_steer;
        o_rec.pedals  = r_last_pedals;
        o_rec.fine    = r_last_fine;
        o_rec.run     = r_run;
        o_rec.pos     = r_wr_pos;
        o_rec.frames  = is_rec ? (r_total + 32'd1) : r_total;
        o_rec.mask    = '0;
        o_rec.mask[drlfe_pkg::SLOT_HDR]     = 1'b1;
        o_rec.mask[drlfe_pkg::SLOT_FLAGS]   = r_last_hdr[0];
        o_rec.mask[drlfe_pkg::SLOT_BUTTONS] = r_last_hdr[1];
        o_rec.mask[drlfe_pkg::SLOT_STEER]   = r_last_hdr[2];
        o_rec.mask[drlfe_pkg::SLOT_PEDALS]  = r_last_hdr[3];
        o_rec.mask[drlfe_pkg::SLOT_FINE_LO] = has_fine;
        o_rec.mask[drlfe_pkg::SLOT_FINE_HI] = has_fine;
        o_rec.mask[drlfe_pkg::SLOT_RUN3]    = (r_run >= 31'h0100_0000);
        o_rec.mask[drlfe_pkg::SLOT_RUN2]    = (r_run >= 31'h0002_0000);
        o_rec.mask[drlfe_pkg::SLOT_RUN1]    = (r_run >= 31'h0000_0400);
        o_rec.mask[drlfe_pkg::SLOT_RUN0]    = long_run;

        n_len   = 4'($countones(o_rec.mask));
        n_pos   = {1'b0, r_wr_pos} + {13'd0, n_len};
        // stop once the unwrapped write position comes within the margin
        cap_hit = ({1'b0, n_pos} + drlfe_pkg::CAPACITY_MARGIN) >= {2'b00, i_capacity};
        o_rec.full = is_rec ? cap_hit : 1'b1;
        o_enq      = i_accept && (rec_flush || end_flush);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hdr     <= 4'd0;
            r_last_flags   <= 8'd0;
            r_last_buttons <= 8'd0;
            r_last_steer   <= 8'd0;
            r_last_pedals  <= 8'd0;
            r_last_fine    <= 16'd0;
            r_run          <= drlfe_pkg::RUN_MAX;
            r_pending      <= 1'b0;
            r_wr_pos       <= 16'd0;
            r_stopped      <= 1'b0;
            r_total        <= 32'd0;
        end else if (i_accept) begin
            if (!is_rec) begin
                r_stopped <= 1'b1;
                if (end_flush) begin
                    r_wr_pos <= n_pos[15:0];
                end
            end else if (!r_stopped) begin
                r_total <= r_total + 32'd1;
                if (r_pending && (chg == 4'd0)) begin
                    // repeat: extend the run, saturating
                    if (r_run != drlfe_pkg::RUN_MAX) begin
                        r_run <= r_run + 31'd1;
                    end
                end else begin
                    if (r_pending) begin
                        r_wr_pos  <= n_pos[15:0];
                        r_stopped <= cap_hit;
                    end
                    r_last_hdr     <= r_pending ? chg : 4'hF;
                    r_last_flags   <= i_frame_flags;
                    r_last_buttons <= i_frame_buttons;
                    r_last_steer   <= i_frame_steer;
                    r_last_pedals  <= pedals;
                    r_last_fine    <= i_wheel_fine;
                    r_run          <= 31'd0;
                    r_pending      <= 1'b1;
                end
            end
        end
    end

endmodule

### hdl/drlfe_queue.sv
`timescale 1ns / 1ps
// Short queue of record descriptors between the front and back ends.
// Uses drlfe_pkg for the descriptor type.
module drlfe_queue #(
    parameter int DEPTH = drlfe_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  drlfe_pkg::t_rec i_rec,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output drlfe_pkg::t_rec o_rec
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    drlfe_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_cnt;

    always_comb begin
        o_full  = (r_cnt == CW'(DEPTH));
        o_valid = (r_cnt != '0);
        o_rec   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### hdl/drlfe_back.sv
`timescale 1ns / 1ps
// Back end: serializes one record descriptor into stream bytes, one per cycle while
// pop takes them, through a registered output stage. Uses drlfe_pkg.
module drlfe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  drlfe_pkg::t_rec i_q_rec,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic [15:0]     o_byte_offset,
    output logic            o_last_byte,
    output logic            o_stream_full,
    output logic [31:0]     o_frames_recorded
);

    drlfe_pkg::t_rec                r_rec;
    logic [drlfe_pkg::NUM_SLOTS-1:0] r_left;
    logic [3:0]                     r_cnt;
    logic                           r_ov;
    logic [7:0]                     r_byte;
    logic [15:0]                    r_offset;
    logic                           r_last;
    logic                           r_full;
    logic [31:0]                    r_frames;

    logic [3:0]                     slot;
    logic [drlfe_pkg::NUM_SLOTS-1:0] low_bit;
    logic                           is_last;
    logic                           adv;
    logic                           load;
    logic                           out_xfer;
    logic [7:0]                     cur_byte;

    always_comb begin
        slot = drlfe_pkg::SLOT_HDR;
        for (int i = drlfe_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_left[i]) begin
                slot = 4'(i);
            end
        end
        low_bit = r_left & (~r_left + {{(drlfe_pkg::NUM_SLOTS - 1){1'b0}}, 1'b1});
        is_last = ((r_left & ~low_bit) == '0);

        case (slot)
            drlfe_pkg::SLOT_HDR:     cur_byte = r_rec.header;
            drlfe_pkg::SLOT_FLAGS:   cur_byte = r_rec.flags;
            drlfe_pkg::SLOT_BUTTONS: cur_byte = r_rec.buttons;
            drlfe_pkg::SLOT_STEER:   cur_byte = r_rec.steer;
            drlfe_pkg::SLOT_PEDALS:  cur_byte = r_rec.pedals;
            drlfe_pkg::SLOT_FINE_LO: cur_byte = r_rec.fine[7:0];
            drlfe_pkg::SLOT_FINE_HI: cur_byte = r_rec.fine[15:8];
            drlfe_pkg::SLOT_RUN3:    cur_byte = {4'hE, r_rec.run[30:27]};
            // prefix bits mark the first byte of a three or two byte count
            drlfe_pkg::SLOT_RUN2:    cur_byte = r_rec.mask[drlfe_pkg::SLOT_RUN3] ?
                                                r_rec.run[26:19] :
                                                {2'b11, r_rec.run[24:19]};
            drlfe_pkg::SLOT_RUN1:    cur_byte = r_rec.mask[drlfe_pkg::SLOT_RUN2] ?
                                                r_rec.run[18:11] :
                                                {1'b1, r_rec.run[17:11]};
            drlfe_pkg::SLOT_RUN0:    cur_byte = r_rec.run[10:3];
            default:                 cur_byte = 8'h00;
        endcase

        out_xfer = i_pop && r_ov;
        adv      = (r_left != '0) && (!r_ov || out_xfer);
        load     = i_q_valid && ((r_left == '0) || (adv && is_last));
        o_q_rd   = load;

        o_empty           = !r_ov;
        o_out_byte        = r_byte;
        o_byte_offset     = r_offset;
        o_last_byte       = r_last;
        o_stream_full     = r_full;
        o_frames_recorded = r_frames;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_rec;
        end
        if (adv) begin
            r_byte   <= cur_byte;
            r_offset <= r_rec.pos + {12'd0, r_cnt};
            r_last   <= is_last;
            r_full   <= r_rec.full;
            r_frames <= r_rec.frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_cnt  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_left <= i_q_rec.mask;
                r_cnt  <= 4'd0;
            end else if (adv) begin
                r_left <= r_left & ~low_bit;
                r_cnt  <= r_cnt + 4'd1;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (out_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

### hdl/delta_run_length_frame_encoder.sv
`timescale 1ns / 1ps
// Delta run-length frame encoder, top level: config port, front, queue, back.
// A flushed record passes through the descriptor queue, the back end's record register and its output register.
// Throughput: one frame per cycle while the descriptor queue has room; the byte
// serializer drains one byte per cycle while pop takes them; a record holds up to 11 bytes.
// Reset: synchronous, active low; clears state at once, no clearing pass.
module delta_run_length_frame_encoder #(
    parameter int QUEUE_DEPTH = drlfe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_frame_flags,
    input  logic [7:0]  i_frame_buttons,
    input  logic [7:0]  i_frame_steer,
    input  logic [7:0]  i_throttle_level,
    input  logic [3:0]  i_brake_level,
    input  logic [15:0] i_wheel_fine,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_offset,
    output logic        o_last_byte,
    output logic        o_stream_full,
    output logic [31:0] o_frames_recorded,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]     r_capacity;
    logic            cfg_wr;
    logic            accept;
    logic            enq;
    logic            q_full;
    logic            q_valid;
    logic            q_rd;
    drlfe_pkg::t_rec enq_rec;
    drlfe_pkg::t_rec q_rec;

    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && (paddr == drlfe_pkg::ADDR_CAPACITY);
        prdata = (paddr == drlfe_pkg::ADDR_CAPACITY) ? {16'd0, r_capacity} : 32'd0;
        full   = q_full;
        accept = push && !q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= drlfe_pkg::CAPACITY_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[15:0];
        end
    end

    drlfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_operation      (i_operation),
        .i_frame_flags    (i_frame_flags),
        .i_frame_buttons  (i_frame_buttons),
        .i_frame_steer    (i_frame_steer),
        .i_throttle_level (i_throttle_level),
        .i_brake_level    (i_brake_level),
        .i_wheel_fine     (i_wheel_fine),
        .i_capacity       (r_capacity),
        .o_enq            (enq),
        .o_rec            (enq_rec)
    );

    drlfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (enq),
        .i_rec   (enq_rec),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    drlfe_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_rec           (q_rec),
        .o_q_rd            (q_rd),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_out_byte        (o_out_byte),
        .o_byte_offset     (o_byte_offset),
        .o_last_byte       (o_last_byte),
        .o_stream_full     (o_stream_full),
        .o_frames_recorded (o_frames_recorded)
    );

endmodule

### verif/tb_delta_run_length_frame_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench of the delta run-length frame encoder: directed and random
// frames, a byte scoreboard with its own encoder prediction. Needs drlfe_pkg and the RTL.
module tb_delta_run_length_frame_encoder;

    localparam logic [1:0]  OP_END_DROP = 2'd2;
    localparam logic [1:0]  OP_END_ALT  = 2'd3;  // decodes as end without flush
    localparam logic [7:0]  HDR_FIRST   = 8'h78;
    localparam logic [7:0]  HDR_FLAGS   = 8'h08;
    localparam logic [7:0]  HDR_BUTTONS = 8'h10;
    localparam logic [7:0]  HDR_STEER   = 8'h20;
    localparam logic [7:0]  HDR_PEDALS  = 8'h40;
    localparam logic [7:0]  HDR_LONG    = 8'h80;
    localparam logic [7:0]  RUN_PREFIX2 = 8'h80;
    localparam logic [7:0]  RUN_PREFIX3 = 8'hC0;
    localparam logic [7:0]  RUN_PREFIX4 = 8'hE0;
    localparam logic [31:0] RUN_CEILING = 32'h7FFF_FFFF;
    localparam logic [15:0] CAP_AT_RESET = 16'd4096;
    localparam int          WHEEL = 7;
    localparam int          STOP_MARGIN = 17;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES = 24;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  flags;
        logic [7:0]  buttons;
        logic [7:0]  steer;
        logic [7:0]  throttle;
        logic [3:0]  brake;
        logic [15:0] fine;
    } t_frame_item;

    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] offset;
        logic        last_byte;
        logic        stream_full;
        logic [31:0] frames;
    } t_enc_byte;

    typedef enum {END_BY_FLUSH, END_TINY_CAPACITY, END_NEAR_CAPACITY} t_ending;

    class t_frame_encoder_scoreboard;
        logic [15:0] capacity;
        logic [7:0]  last_hdr, last_flags, last_buttons, last_steer, last_pedals;
        logic [15:0] last_fine;
        logic [31:0] run_len;
        logic [15:0] wr_pos;
        bit          stopped;
        logic [31:0] frame_count;
        logic [31:0] cursor;
        t_enc_byte   record_bytes[$];
        t_enc_byte   expected_bytes[$];
        int          faults;
        int          bytes_checked;

        function new();
            capacity = CAP_AT_RESET;
            last_hdr = '0;
            last_flags = '0;
            last_buttons = '0;
            last_steer = '0;
            last_pedals = '0;
            last_fine = '0;
            run_len = '1;
            wr_pos = '0;
            stopped = 1'b0;
            frame_count = '0;
            cursor = '0;
            faults = 0;
            bytes_checked = 0;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        function string show(t_enc_byte b);
            return $sformatf("byte %02h off %0d last %0b full %0b frames %0d",
                             b.value, b.offset, b.last_byte, b.stream_full, b.frames);
        endfunction

        function void emit_byte(logic [7:0] v);
            t_enc_byte b;
            b.value = v;
            b.offset = cursor[15:0];
            b.last_byte = 1'b0;
            b.stream_full = 1'b0;
            b.frames = frame_count;
            record_bytes = {record_bytes, b};
            cursor = cursor + 1;
        endfunction

        // Serialize the pending record: header, changed fields, run count above 3 bits.
        function void emit_record();
            logic [31:0] run, count;
            logic [7:0]  hdr;
            t_enc_byte   b;
            run = run_len;
            count = run >> 3;
            cursor = {16'h0, wr_pos};
            record_bytes.delete();
            hdr = {last_hdr[7:3], run[2:0]};
            if (run > 32'd7) hdr |= HDR_LONG;
            emit_byte(hdr);
            if ((hdr & HDR_FLAGS) != 0) emit_byte(last_flags);
            if ((hdr & HDR_BUTTONS) != 0) emit_byte(last_buttons);
            if ((hdr & HDR_STEER) != 0) emit_byte(last_steer);
            if ((hdr & HDR_PEDALS) != 0) begin
                emit_byte(last_pedals);
                if (last_flags[WHEEL]) begin
                    emit_byte(last_fine[7:0]);
                    emit_byte(last_fine[15:8]);
                end
            end
            if ((hdr & HDR_LONG) != 0) begin
                if (count >= 32'h0020_0000) begin
                    emit_byte(RUN_PREFIX4 | 8'(run >> 27));
                    emit_byte(8'(run >> 19));
                    emit_byte(8'(count >> 8));
                end else if (count > 32'h3FFF) begin
                    emit_byte(RUN_PREFIX3 | 8'(run >> 19));
                    emit_byte(8'(count >> 8));
                end else if (count > 32'h7F) begin
                    emit_byte(RUN_PREFIX2 | 8'(count >> 8));
                end
                emit_byte(8'(count));
            end
            wr_pos = cursor[15:0];
            if (int'(capacity) - STOP_MARGIN <= int'(cursor)) stopped = 1'b1;
            foreach (record_bytes[k]) begin
                b = record_bytes[k];
                b.stream_full = stopped;
                b.last_byte = (k == record_bytes.size() - 1);
                expected_bytes = {expected_bytes, b};
            end
        endfunction

        function void note_frame(t_frame_item it);
            logic [7:0] pedals, hdr;
            bit         pending, was_stopped;
            pedals = it.throttle | {it.brake, 4'h0};
            pending = !run_len[31];
            if (it.op != drlfe_pkg::OP_RECORD) begin
                was_stopped = stopped;
                stopped = 1'b1;
                if (!was_stopped && it.op == drlfe_pkg::OP_END_FLUSH && pending) emit_record();
                return;
            end
            if (stopped) return;
            frame_count = frame_count + 1;
            hdr = HDR_FIRST;
            if (pending) begin
                hdr = '0;
                if (it.flags != last_flags) hdr |= HDR_FLAGS;
                if (it.buttons != last_buttons) hdr |= HDR_BUTTONS;
                if (it.steer != last_steer) hdr |= HDR_STEER;
                if (pedals != last_pedals) hdr |= HDR_PEDALS;
                if (it.flags[WHEEL] && (!last_flags[WHEEL] || it.fine != last_fine))
                    hdr |= HDR_PEDALS;
                if (hdr == '0) begin
                    // same frame: lengthen the run, saturating
                    if (run_len < RUN_CEILING) run_len = run_len + 1;
                    return;
                end
                emit_record();
            end
            last_hdr = hdr;
            last_flags = it.flags;
            last_buttons = it.buttons;
            last_steer = it.steer;
            last_pedals = pedals;
            last_fine = it.fine;
            run_len = '0;
        endfunction

        function void check_byte(t_enc_byte got);
            t_enc_byte want;
            if (expected_bytes.size() == 0) begin
                note_fault($sformatf("unexpected %s", show(got)));
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got !== want)
                note_fault($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_operation = '0;
    logic [7:0]  i_frame_flags = '0;
    logic [7:0]  i_frame_buttons = '0;
    logic [7:0]  i_frame_steer = '0;
    logic [7:0]  i_throttle_level = '0;
    logic [3:0]  i_brake_level = '0;
    logic [15:0] i_wheel_fine = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic [15:0] o_byte_offset;
    logic        o_last_byte;
    logic        o_stream_full;
    logic [31:0] o_frames_recorded;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_frame_encoder_scoreboard sb = new();
    t_frame_item cur_frame;
    t_enc_byte   seen;
    t_ending     ending;
    int          pop_wait = 0;
    int          cap_writes = 0;
    bit          calm = 1'b0;

    delta_run_length_frame_encoder DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_operation       (i_operation),
        .i_frame_flags     (i_frame_flags),
        .i_frame_buttons   (i_frame_buttons),
        .i_frame_steer     (i_frame_steer),
        .i_throttle_level  (i_throttle_level),
        .i_brake_level     (i_brake_level),
        .i_wheel_fine      (i_wheel_fine),
        .empty             (empty),
        .pop               (pop),
        .o_out_byte        (o_out_byte),
        .o_byte_offset     (o_byte_offset),
        .o_last_byte       (o_last_byte),
        .o_stream_full     (o_stream_full),
        .o_frames_recorded (o_frames_recorded),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Result side: check each transfer, then hold pop low for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen = {o_out_byte, o_byte_offset, o_last_byte, o_stream_full, o_frames_recorded};
            sb.check_byte(seen);
            pop_wait = draw_wait();
        end
        if (pop_wait > 0) begin
            pop_wait--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_item(t_frame_item it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        {i_operation, i_frame_flags, i_frame_buttons, i_frame_steer,
         i_throttle_level, i_brake_level, i_wheel_fine} <= it;
        do @(posedge i_clk); while (full);
        sb.note_frame(it);
    endtask

    task automatic drain_results(int settle);
        push <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= drlfe_pkg::ADDR_CAPACITY;
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.capacity = value;
        cap_writes++;
        // read it back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== value)
            sb.note_fault($sformatf("capacity reads back %04h, wrote %04h", prdata[15:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly small edits of the last frame; about a third are repeats as the encoder sees them.
    function automatic t_frame_item next_frame(t_frame_item prev);
        t_frame_item f;
        logic [7:0]  pedals;
        bit          changed;
        f = prev;
        f.op = drlfe_pkg::OP_RECORD;
        if ($urandom_range(0, 99) < 35) begin
            pedals = prev.throttle | {prev.brake, 4'h0};
            if ($urandom_range(0, 2) == 0) begin
                // alias: other throttle and brake giving the same pedal byte
                f.throttle = pedals;
                f.brake = pedals[7:4] & 4'($urandom);
            end
            if (!prev.flags[WHEEL]) f.fine = 16'($urandom);
            return f;
        end
        changed = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
            f.flags = 8'($urandom);
            changed = 1'b1;
        end
        if ($urandom_range(0, 2) == 0) begin
            f.buttons = 8'($urandom);
            changed = 1'b1;
        end
        if ($urandom_range(0, 2) == 0) begin
            f.steer = 8'($urandom);
            changed = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) begin
            f.throttle = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
            f.brake = 4'($urandom);
            changed = 1'b1;
        end
        if ($urandom_range(0, 1) == 0) begin
            f.fine = 16'($urandom);
            if (f.flags[WHEEL]) changed = 1'b1;
        end
        if (!changed) f.steer = f.steer ^ 8'($urandom_range(1, 255));
        return f;
    endfunction

    initial begin
        t_frame_item d;
        logic [1:0]  late_ops[4];
        late_ops = '{drlfe_pkg::OP_RECORD, drlfe_pkg::OP_END_FLUSH, OP_END_DROP, OP_END_ALT};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_capacity(16'hFFFF);

        d = '0;
        send_item(d);                // first frame: stored, nothing emitted
        d.flags = 8'hFF;
        d.buttons = 8'hFF;
        d.steer = 8'hFF;
        d.throttle = 8'hFF;
        d.brake = 4'hF;
        d.fine = 16'hFFFF;
        repeat (8) send_item(d);     // all fields change, then a run of seven
        d.fine = 16'h0000;
        repeat (9) send_item(d);     // fine word alone changes, then a run of eight
        d.flags = 8'h7F;
        send_item(d);
        d.buttons = 8'h5A;
        send_item(d);
        d.steer = 8'hA5;
        send_item(d);
        d.throttle = 8'h0F;
        d.brake = 4'h0;
        send_item(d);
        d.flags = 8'h80;
        d.throttle = 8'h30;
        d.fine = 16'h1234;
        send_item(d);                // back into wheel mode
        d.throttle = 8'h05;
        d.brake = 4'hA;
        send_item(d);
        d.throttle = 8'hA5;
        d.brake = 4'h2;
        send_item(d);                // same pedal byte from other inputs
        cur_frame = d;

        for (int phase = 0; phase < 6; phase++) begin
            drain_results(SETTLE_CYCLES);
            if (phase > 0)
                write_capacity(16'($urandom_range(int'(sb.wr_pos) + 1000, 65535)));
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 50; n++) begin
                cur_frame = next_frame(cur_frame);
                send_item(cur_frame);
            end
        end

        drain_results(SETTLE_CYCLES);
        calm = 1'b0;
        ending = t_ending'($urandom_range(0, 2));
        case (ending)
            END_BY_FLUSH: begin
                d = next_frame(cur_frame);
                d.op = drlfe_pkg::OP_END_FLUSH;
                send_item(d);
            end
            default: begin
                if (ending == END_TINY_CAPACITY)
                    write_capacity($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 16)));
                else
                    write_capacity(16'(int'(sb.wr_pos) + STOP_MARGIN + $urandom_range(10, 150)));
                while (!sb.stopped) begin
                    cur_frame = next_frame(cur_frame);
                    send_item(cur_frame);
                end
            end
        endcase

        // stream has stopped: all of these must be dropped
        for (int n = 0; n < 8; n++) begin
            d = next_frame(cur_frame);
            d.op = late_ops[n % 4];
            send_item(d);
        end
        drain_results(TAIL_CYCLES);

        $display("Covered %0d recorded frames, %0d stream bytes checked, %0d capacity writes.",
                 sb.frame_count, sb.bytes_checked, cap_writes);
        $display("Stream stopped by %s, final write offset %0d.", ending.name(), sb.wr_pos);
        if (sb.faults == 0 && sb.expected_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### delta_run_length_frame_encoder.f
hdl/drlfe_pkg.sv
hdl/drlfe_front.sv
hdl/drlfe_queue.sv
hdl/drlfe_back.sv
hdl/delta_run_length_frame_encoder.sv
verif/tb_delta_run_length_frame_encoder.sv
